[rtl/sha1md_pkg.sv]
// SHA-1 message digest: shared types and constants.
// Depends on nothing; used by sha1_message_digest_top.
`default_nettype none

package sha1md_pkg;

    localparam int unsigned WORD_BITS   = 32;
    localparam int unsigned CHAIN_WORDS = 5;
    localparam int unsigned SCHED_WORDS = 16;
    localparam int unsigned ROUNDS      = 80;
    localparam int unsigned TOTAL_BITS  = 61;

    localparam logic [7:0] PAD_MARK  = 8'h80;
    localparam logic [5:0] LAST_POS  = 6'd63;
    localparam logic [5:0] LEN_POS   = 6'd56;
    localparam logic [6:0] LAST_RND  = 7'd79;

    localparam logic [31:0] K_00_19 = 32'h5A827999;
    localparam logic [31:0] K_20_39 = 32'h6ED9EBA1;
    localparam logic [31:0] K_40_59 = 32'h8F1BBCDC;
    localparam logic [31:0] K_60_79 = 32'hCA62C1D6;

    localparam logic [31:0] H_INIT [CHAIN_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last_byte;
    } msg_word_t;

    typedef struct packed {
        logic [31:0] digest_word0;
        logic [31:0] digest_word1;
        logic [31:0] digest_word2;
        logic [31:0] digest_word3;
        logic [31:0] digest_word4;
    } dig_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

[rtl/sha1_message_digest_top.sv]
// SHA-1 message digest, byte-serial input, one shared round unit.
// Depends on sha1md_pkg (types, round constants, initial chaining values).
//
// Usage: feed message bytes one word at a time (has_byte=1); mark the final
// word with last_byte=1 (has_byte=0 with last_byte=1 ends a message without
// a byte; on its own it gives the empty-message digest). An ordinary byte is
// taken without a stall. Every 64th byte starts a compression: one shared
// round unit runs the 80 rounds one per cycle, then the ST_ADD state adds
// the result into the chaining words. After the last word the padding (0x80,
// zeros, bit length) is fed through the same byte packer one byte per cycle,
// with a second block of padding when the length no longer fits; each block
// is compressed in turn, then the digest register is loaded. msg_stall is
// high for all of that time. The digest sits in an output register, so the
// next message may start while it waits to be taken; a new digest is held
// back only while the old one is unread. The byte count saturates at
// 2^61-1; the length field carries the low LENGTH_FIELD_BITS bits of the
// bit count, higher bits zero.
`default_nettype none

module sha1_message_digest_top #(
    parameter int unsigned LENGTH_FIELD_BITS = 64
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    msg_valid,
    output logic                   msg_stall,
    input  sha1md_pkg::msg_word_t  msg_word,
    output logic                   dig_valid,
    input  wire                    dig_stall,
    output sha1md_pkg::dig_word_t  dig_word
);

    localparam int unsigned NCH = sha1md_pkg::CHAIN_WORDS;
    localparam int unsigned NSC = sha1md_pkg::SCHED_WORDS;
    localparam int unsigned TB  = sha1md_pkg::TOTAL_BITS;

    // control state
    sha1md_pkg::state_t state_reg, state_next;
    logic [5:0]    fill_reg, fill_next;          // byte position in block
    logic [6:0]    rnd_reg, rnd_next;            // round counter 0..79 in ST_ROUND
    logic [TB-1:0] total_reg, total_next;        // saturating byte count
    logic          pad_mode_reg, pad_mode_next;  // padding current message
    logic          first_pad_reg, first_pad_next;
    logic          len_ok_reg, len_ok_next;      // length goes in this block
    logic          final_reg, final_next;        // this compression ends msg
    logic          dig_valid_reg, dig_valid_next;

    // datapath
    logic [31:0] word_reg, word_next;            // byte packer
    logic [31:0] sched_reg [NSC];
    logic [31:0] rw_reg [NCH];
    logic [31:0] rw_next [NCH];
    logic [31:0] chain_reg [NCH];
    logic [31:0] chain_next [NCH];
    sha1md_pkg::dig_word_t dig_reg;

    // handshake and sequencing terms
    logic        accept;
    logic        push_en;
    logic [7:0]  push_byte;
    logic        block_full;
    logic        emit;
    logic        shift_en;
    logic [31:0] shift_in;

    // length field
    logic [63:0] len_raw;
    logic [63:0] len_bits;
    logic [7:0]  len_byte;

    // round unit
    logic [31:0] w_new;
    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] t_val;

    assign msg_stall = (state_reg != sha1md_pkg::ST_IDLE);
    assign accept    = msg_valid && !msg_stall;
    assign dig_valid = dig_valid_reg;
    assign dig_word  = dig_reg;
    assign emit      = (state_reg == sha1md_pkg::ST_EMIT) && (!dig_valid_reg || !dig_stall);

    // bit count, cut to the configured field width
    assign len_raw = {total_reg, 3'b000};
    always_comb
    begin
        for (int i = 0; i < 64; i++)
        begin
            len_bits[i] = (i < int'(LENGTH_FIELD_BITS)) ? len_raw[i] : 1'b0;
        end
    end
    // byte 56 of the block carries the top byte of the length
    assign len_byte = len_bits[{~fill_reg[2:0], 3'b000} +: 8];

    // byte source: message bytes when idle, pad bytes while padding
    always_comb
    begin
        push_en   = 1'b0;
        push_byte = msg_word.data_byte;
        if (state_reg == sha1md_pkg::ST_IDLE)
        begin
            push_en = accept && msg_word.has_byte;
        end
        else if (state_reg == sha1md_pkg::ST_PAD)
        begin
            push_en = 1'b1;
            if (first_pad_reg)
                push_byte = sha1md_pkg::PAD_MARK;
            else if (len_ok_reg && fill_reg >= sha1md_pkg::LEN_POS)
                push_byte = len_byte;
            else
                push_byte = 8'h00;
        end
    end
    assign block_full = push_en && (fill_reg == sha1md_pkg::LAST_POS);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sha1md_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (block_full)
                        state_next = sha1md_pkg::ST_ROUND;
                    else if (msg_word.last_byte)
                        state_next = sha1md_pkg::ST_PAD;
                end
            end
            sha1md_pkg::ST_PAD:
            begin
                if (block_full)
                    state_next = sha1md_pkg::ST_ROUND;
            end
            sha1md_pkg::ST_ROUND:
            begin
                if (rnd_reg == sha1md_pkg::LAST_RND)
                    state_next = sha1md_pkg::ST_ADD;
            end
            sha1md_pkg::ST_ADD:
            begin
                if (final_reg)
                    state_next = sha1md_pkg::ST_EMIT;
                else if (pad_mode_reg)
                    state_next = sha1md_pkg::ST_PAD;
                else
                    state_next = sha1md_pkg::ST_IDLE;
            end
            sha1md_pkg::ST_EMIT:
            begin
                if (emit)
                    state_next = sha1md_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = sha1md_pkg::ST_IDLE;
            end
        endcase
    end

    // round unit: one SHA-1 round per cycle, schedule from a 16-word shift line
    assign w_new = {sched_reg[13] ^ sched_reg[8] ^ sched_reg[2] ^ sched_reg[0]}
                   <<< 0;
    always_comb
    begin
        if (rnd_reg < 7'd20)
        begin
            f_val = (rw_reg[1] & rw_reg[2]) | (~rw_reg[1] & rw_reg[3]);
            k_val = sha1md_pkg::K_00_19;
        end
        else if (rnd_reg < 7'd40)
        begin
            f_val = rw_reg[1] ^ rw_reg[2] ^ rw_reg[3];
            k_val = sha1md_pkg::K_20_39;
        end
        else if (rnd_reg < 7'd60)
        begin
            f_val = (rw_reg[1] & rw_reg[2]) | (rw_reg[1] & rw_reg[3])
                  | (rw_reg[2] & rw_reg[3]);
            k_val = sha1md_pkg::K_40_59;
        end
        else
        begin
            f_val = rw_reg[1] ^ rw_reg[2] ^ rw_reg[3];
            k_val = sha1md_pkg::K_60_79;
        end
    end
    assign t_val = {rw_reg[0][26:0], rw_reg[0][31:27]} + f_val + rw_reg[4]
                 + sched_reg[0] + k_val;

    // schedule shift: packed message words, or the next expanded word
    always_comb
    begin
        shift_en = 1'b0;
        shift_in = {w_new[30:0], w_new[31]};
        if (state_reg == sha1md_pkg::ST_ROUND)
        begin
            shift_en = 1'b1;
        end
        else if (push_en && fill_reg[1:0] == 2'b11)
        begin
            shift_en = 1'b1;
            shift_in = {word_reg[23:0], push_byte};
        end
    end

    // control and datapath next values
    always_comb
    begin
        fill_next      = fill_reg;
        rnd_next       = rnd_reg;
        total_next     = total_reg;
        pad_mode_next  = pad_mode_reg;
        first_pad_next = first_pad_reg;
        len_ok_next    = len_ok_reg;
        final_next     = final_reg;
        word_next      = word_reg;
        dig_valid_next = dig_valid_reg && dig_stall;
        for (int i = 0; i < NCH; i++)
        begin
            rw_next[i]    = rw_reg[i];
            chain_next[i] = chain_reg[i];
        end

        if (push_en)
        begin
            word_next = {word_reg[23:0], push_byte};
            fill_next = fill_reg + 6'd1;
        end
        if (block_full)
        begin
            rnd_next = '0;
            for (int i = 0; i < NCH; i++)
                rw_next[i] = chain_reg[i];
        end

        if (state_reg == sha1md_pkg::ST_IDLE && accept)
        begin
            if (msg_word.has_byte && !(&total_reg))
                total_next = total_reg + TB'(1);
            if (msg_word.last_byte)
            begin
                pad_mode_next  = 1'b1;
                first_pad_next = 1'b1;
            end
        end

        if (state_reg == sha1md_pkg::ST_PAD)
        begin
            first_pad_next = 1'b0;
            // the mark landing at or before byte 55 leaves room for the length
            if (first_pad_reg && fill_reg < sha1md_pkg::LEN_POS)
                len_ok_next = 1'b1;
            if (block_full && len_ok_reg)
                final_next = 1'b1;
        end

        if (state_reg == sha1md_pkg::ST_ROUND)
        begin
            rnd_next   = rnd_reg + 7'd1;
            rw_next[4] = rw_reg[3];
            rw_next[3] = rw_reg[2];
            rw_next[2] = {rw_reg[1][1:0], rw_reg[1][31:2]};
            rw_next[1] = rw_reg[0];
            rw_next[0] = t_val;
        end

        if (state_reg == sha1md_pkg::ST_ADD)
        begin
            for (int i = 0; i < NCH; i++)
                chain_next[i] = chain_reg[i] + rw_reg[i];
            if (pad_mode_reg)
                len_ok_next = 1'b1;
        end

        if (emit)
        begin
            dig_valid_next = 1'b1;
            for (int i = 0; i < NCH; i++)
                chain_next[i] = sha1md_pkg::H_INIT[i];
            total_next    = '0;
            pad_mode_next = 1'b0;
            len_ok_next   = 1'b0;
            final_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sha1md_pkg::ST_IDLE;
            fill_reg      <= '0;
            rnd_reg       <= '0;
            total_reg     <= '0;
            pad_mode_reg  <= 1'b0;
            first_pad_reg <= 1'b0;
            len_ok_reg    <= 1'b0;
            final_reg     <= 1'b0;
            dig_valid_reg <= 1'b0;
            for (int i = 0; i < NCH; i++)
                chain_reg[i] <= sha1md_pkg::H_INIT[i];
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            rnd_reg       <= rnd_next;
            total_reg     <= total_next;
            pad_mode_reg  <= pad_mode_next;
            first_pad_reg <= first_pad_next;
            len_ok_reg    <= len_ok_next;
            final_reg     <= final_next;
            dig_valid_reg <= dig_valid_next;
            for (int i = 0; i < NCH; i++)
                chain_reg[i] <= chain_next[i];
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        for (int i = 0; i < NCH; i++)
            rw_reg[i] <= rw_next[i];
        if (shift_en)
        begin
            for (int i = 0; i < NSC - 1; i++)
                sched_reg[i] <= sched_reg[i + 1];
            sched_reg[NSC - 1] <= shift_in;
        end
        if (emit)
        begin
            dig_reg.digest_word0 <= chain_reg[0];
            dig_reg.digest_word1 <= chain_reg[1];
            dig_reg.digest_word2 <= chain_reg[2];
            dig_reg.digest_word3 <= chain_reg[3];
            dig_reg.digest_word4 <= chain_reg[4];
        end
    end

    // checks
    a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sha1md_pkg::ST_ROUND |-> rnd_reg <= sha1md_pkg::LAST_RND)
        else $error("round counter past last round");

    a_block_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != sha1md_pkg::ST_ROUND && state_next == sha1md_pkg::ST_ROUND)
        |=> fill_reg == '0)
        else $error("compression started on a partial block");

    a_final_in_pad: assert property (@(posedge clk) disable iff (!rst_n)
        final_reg |-> pad_mode_reg && len_ok_reg)
        else $error("final compression outside padding");

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> total_reg == '0 && fill_reg == '0 && dig_valid_reg
                 && !pad_mode_reg)
        else $error("message state not cleared after digest");

endmodule

`default_nettype wire

[dv/sha1_digest_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for sha1_message_digest_top: follows both channels, keeps its own SHA-1 state
// and compares each digest taken with the oldest one it predicted.
// Depends on sha1md_pkg for the channel word types.

module sha1_digest_checker #(
    parameter int unsigned LEN_BITS = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  msg_valid,
    input  logic                  msg_stall,
    input  sha1md_pkg::msg_word_t msg_word,
    input  logic                  dig_valid,
    input  logic                  dig_stall,
    input  sha1md_pkg::dig_word_t dig_word,
    output int                    errors,
    output int                    digests_due
);

    localparam logic [31:0] IV [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };
    localparam logic [31:0] RK [4] = '{
        32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
    };
    localparam int unsigned STRAY_SHOW = 20;

    logic [31:0]            hash_h [5];
    logic [31:0]            sched [16];
    logic [60:0]            msg_bytes;
    int unsigned            blk_pos;
    sha1md_pkg::dig_word_t  digest_q [$];
    int                     err_count = 0;
    int unsigned            stray_count = 0;

    initial errors = 0;
    initial digests_due = 0;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic put_byte(input int unsigned pos, input logic [7:0] val);
        sched[(pos >> 2) & 15][(3 - (pos & 3)) * 8 +: 8] = val;
    endtask

    // 80 rounds over sched, folded into hash_h
    task automatic run_rounds();
        logic [31:0] a, b, c, d, e, w, f, k, t;
        int unsigned r;
        a = hash_h[0];
        b = hash_h[1];
        c = hash_h[2];
        d = hash_h[3];
        e = hash_h[4];
        for (r = 0; r < 80; r++)
        begin
            if (r < 16)
                w = sched[r];
            else
            begin
                w = rotl(sched[(r - 3) & 15] ^ sched[(r - 8) & 15] ^
                         sched[(r - 14) & 15] ^ sched[r & 15], 1);
                sched[r & 15] = w;
            end
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = RK[0];
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = RK[1];
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = RK[2];
            end
            else
            begin
                f = b ^ c ^ d;
                k = RK[3];
            end
            t = rotl(a, 5) + f + e + w + k;
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        hash_h[0] += a;
        hash_h[1] += b;
        hash_h[2] += c;
        hash_h[3] += d;
        hash_h[4] += e;
    endtask

    task automatic clear_state();
        hash_h = IV;
        foreach (sched[i])
            sched[i] = '0;
        msg_bytes = '0;
        blk_pos = 0;
        digest_q.delete();
    endtask

    task automatic take_word(input sha1md_pkg::msg_word_t w);
        logic [63:0] len;
        if (w.has_byte)
        begin
            put_byte(blk_pos, w.data_byte);
            blk_pos++;
            if (msg_bytes != '1)
                msg_bytes++;
            if (blk_pos == 64)
            begin
                run_rounds();
                blk_pos = 0;
            end
        end
        if (!w.last_byte)
            return;
        // pad: marker byte, zeros, 64-bit length; a second block if the length won't fit
        put_byte(blk_pos, 8'h80);
        blk_pos++;
        if (blk_pos > 56)
        begin
            while (blk_pos < 64)
            begin
                put_byte(blk_pos, 8'h00);
                blk_pos++;
            end
            run_rounds();
            blk_pos = 0;
        end
        while (blk_pos < 56)
        begin
            put_byte(blk_pos, 8'h00);
            blk_pos++;
        end
        len = {msg_bytes, 3'b000};
        if (LEN_BITS < 64)
            len &= (64'd1 << LEN_BITS) - 64'd1;
        sched[14] = len[63:32];
        sched[15] = len[31:0];
        run_rounds();
        digest_q.push_back({hash_h[0], hash_h[1], hash_h[2], hash_h[3], hash_h[4]});
        hash_h = IV;
        msg_bytes = '0;
        blk_pos = 0;
    endtask

    task automatic check_digest(input sha1md_pkg::dig_word_t got);
        sha1md_pkg::dig_word_t want;
        int unsigned i;
        if (digest_q.size() == 0)
        begin
            err_count++;
            stray_count++;
            if (stray_count <= STRAY_SHOW)
                $display("%0t: digest %h taken, expected none", $time, got);
            return;
        end
        want = digest_q.pop_front();
        for (i = 0; i < 5; i++)
        begin
            if (want[159 - 32 * i -: 32] !== got[159 - 32 * i -: 32])
            begin
                err_count++;
                $display("%0t: digest_word%0d expected %08h got %08h", $time, i,
                         want[159 - 32 * i -: 32], got[159 - 32 * i -: 32]);
            end
        end
    endtask

    // digest side first, so a digest can never match one predicted in the same cycle
    always @(posedge clk)
    begin
        if (!rst_n)
            clear_state();
        else
        begin
            if (dig_valid && !dig_stall)
                check_digest(dig_word);
            if (msg_valid && !msg_stall)
                take_word(msg_word);
        end
        errors <= err_count;
        digests_due <= digest_q.size();
    end

endmodule

[dv/sha1_message_digest_top_tb.sv]
`timescale 1ns / 100ps
// Testbench top for sha1_message_digest_top: sends message words, plays the digest
// receiver and gives the verdict. Depends on sha1md_pkg, the block and sha1_digest_checker.

module sha1_message_digest_top_tb;

    localparam int unsigned WORD_TARGET    = 850;  // message bytes and end markers
    localparam int unsigned MSG_TARGET     = 40;   // keep going until this many messages
    localparam int unsigned HOLD_AT        = 250;
    localparam int unsigned PAUSE_AT       = 520;
    localparam int unsigned QUIET_FROM     = 760;  // no idling on either side after this
    localparam int unsigned HOLD_CYCLES    = 1500;
    // a message end costs padding of at most two blocks, two compressions and the digest load
    localparam int unsigned DRAIN_CYCLES   = 320;
    // longest correct gap is the hold-off plus one message end; this is several times that
    localparam int unsigned WATCHDOG_LIMIT = 10000;

    // lengths where the pad just fits, just misses, or lands on a block boundary
    localparam int unsigned PAD_EDGES [6] = '{55, 56, 63, 64, 119, 120};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  msg_valid = 1'b0;
    logic                  msg_stall;
    sha1md_pkg::msg_word_t msg_word = '0;
    logic                  dig_valid;
    logic                  dig_stall = 1'b0;
    sha1md_pkg::dig_word_t dig_word;

    int errors;
    int digests_due;

    bit          quiet = 1'b0;     // set for the tail of the run
    bit          hold_req = 1'b0;  // asks the receiver for one long hold-off
    int unsigned words_sent = 0;
    int unsigned msgs_sent = 0;
    int unsigned longest = 0;
    int unsigned digests_seen = 0;
    int unsigned idle_cycles = 0;

    always #2 clk = ~clk;

    sha1_message_digest_top #(
        .LENGTH_FIELD_BITS(64)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg_stall (msg_stall),
        .msg_word  (msg_word),
        .dig_valid (dig_valid),
        .dig_stall (dig_stall),
        .dig_word  (dig_word)
    );

    sha1_digest_checker #(
        .LEN_BITS(64)
    ) digest_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .msg_valid   (msg_valid),
        .msg_stall   (msg_stall),
        .msg_word    (msg_word),
        .dig_valid   (dig_valid),
        .dig_stall   (dig_stall),
        .dig_word    (dig_word),
        .errors      (errors),
        .digests_due (digests_due)
    );

    always @(posedge clk)
    begin
        if (rst_n && dig_valid && !dig_stall)
            digests_seen <= digests_seen + 1;
    end

    // Watchdog: counts cycles in which neither channel moves a word.
    always @(posedge clk)
    begin
        if ((msg_valid && !msg_stall) || (dig_valid && !dig_stall))
            idle_cycles <= 0;
        else if (idle_cycles < WATCHDOG_LIMIT)
            idle_cycles <= idle_cycles + 1;
        else
        begin
            $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("sha1_message_digest_top_tb: done, errors");
            $finish;
        end
    end

    // Digest receiver: random stall bursts, calm stretches, one long hold-off on
    // request, and never a stall once the run goes quiet.
    initial
    begin : digest_sink
        int unsigned burst;
        int unsigned calm;
        int unsigned pick;
        burst = 0;
        calm = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                // hold long enough that the output register fills and the block
                // has to stall its input behind the next digest
                hold_req = 1'b0;
                dig_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                dig_stall <= 1'b0;
            end
            else if (quiet)
                dig_stall <= 1'b0;
            else if (burst != 0)
            begin
                dig_stall <= 1'b1;
                burst--;
            end
            else if (calm != 0)
            begin
                dig_stall <= 1'b0;
                calm--;
            end
            else
            begin
                dig_stall <= 1'b0;
                pick = $urandom_range(0, 39);
                if (pick == 0)
                    calm = $urandom_range(100, 300);
                else if (pick < 6)
                    burst = $urandom_range(1, 11);
            end
        end
    end

    // Offer one word and hold it until the block takes it. With gaps on, the sender
    // may then drop valid for a random burst.
    task automatic put_word(input logic [7:0] d, input logic has, input logic last,
                            input bit gaps);
        msg_valid <= 1'b1;
        msg_word <= {d, has, last};
        @(posedge clk);
        while (msg_stall)
            @(posedge clk);
        if (has || last)
            words_sent++;
        if (gaps && !quiet && $urandom_range(0, 7) == 0)
        begin
            msg_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    // One message of random bytes. It ends either with last on the final byte or with
    // a separate end marker (has_byte low); an empty message always uses the marker.
    // Idle words are sprinkled in as noise.
    task automatic send_message(input int unsigned len, input bit use_marker);
        bit gaps;
        int unsigned i;
        gaps = ($urandom_range(0, 3) != 0);
        if (len == 0)
            use_marker = 1'b1;
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                put_word(8'($urandom), 1'b0, 1'b0, gaps);
            put_word(8'($urandom), 1'b1, !use_marker && i == len - 1, gaps);
        end
        if (use_marker)
            put_word(8'($urandom), 1'b0, 1'b1, gaps);
        msgs_sent++;
        if (len > longest)
            longest = len;
    endtask

    // Mostly short messages so digests come often; some long ones cross blocks.
    function automatic int unsigned pick_length();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 60)
            return $urandom_range(0, 20);
        else if (sel < 88)
            return $urandom_range(21, 70);
        else
            return $urandom_range(71, 130);
    endfunction

    // Sender idles until every predicted digest has been taken.
    task automatic wait_drained();
        @(posedge clk);
        while (digests_due != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        int unsigned msg_idx;
        bit          held;
        bit          paused;
        msg_idx = 0;
        held = 1'b0;
        paused = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty message, an idle word, "abc", bytes 00/FF closed by an end
        // marker, single-byte messages at the extremes, and an empty message right
        // after a finished one.
        put_word(8'h00, 1'b0, 1'b1, 1'b0);
        put_word(8'h5A, 1'b0, 1'b0, 1'b0);
        put_word(8'h61, 1'b1, 1'b0, 1'b0);
        put_word(8'h62, 1'b1, 1'b0, 1'b0);
        put_word(8'h63, 1'b1, 1'b1, 1'b0);
        put_word(8'h00, 1'b1, 1'b0, 1'b0);
        put_word(8'hFF, 1'b1, 1'b0, 1'b0);
        put_word(8'hC3, 1'b0, 1'b1, 1'b0);
        put_word(8'hFF, 1'b1, 1'b1, 1'b0);
        put_word(8'h00, 1'b1, 1'b1, 1'b0);
        put_word(8'hA5, 1'b0, 1'b1, 1'b0);
        msgs_sent += 6;

        // Random: pad edge lengths first, then random lengths and random endings.
        while (words_sent < WORD_TARGET || msgs_sent < MSG_TARGET)
        begin
            if (!held && words_sent >= HOLD_AT)
            begin
                // short messages queue up behind the receiver's hold-off
                held = 1'b1;
                hold_req = 1'b1;
                repeat (4) send_message($urandom_range(0, 6), 1'($urandom_range(0, 1)));
            end
            if (!paused && words_sent >= PAUSE_AT)
            begin
                paused = 1'b1;
                msg_valid <= 1'b0;
                wait_drained();
            end
            if (words_sent >= QUIET_FROM)
                quiet = 1'b1;
            if (msg_idx < 6)
                send_message(PAD_EDGES[msg_idx], 1'($urandom_range(0, 1)));
            else
                send_message(pick_length(), $urandom_range(0, 3) == 0);
            msg_idx++;
        end

        msg_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run: %0d message words in %0d messages (longest %0d bytes), %0d digests taken",
                 words_sent, msgs_sent, longest, digests_seen);
        $display("run: empty and end-marker messages, pad edge lengths, idle noise, "
                 , "%0d-cycle receiver hold-off", HOLD_CYCLES);
        if (errors == 0 && digests_due == 0)
            $display("sha1_message_digest_top_tb: done, clean");
        else
            $display("sha1_message_digest_top_tb: done, errors");
        $finish;
    end

endmodule
